// ----- rtl/core/cal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types, sizes and codes for the cursor array list.
// ----------------------------------------------------------------------------
package cal_pkg;

    // Built depth of the entry store.
    localparam int DEPTH = 16;
    // Index width into the store and width of a count that can reach DEPTH.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width of the capacity register field.
    localparam int MAXE_W = 5;
    // Width used when comparing the count against the capacity.
    localparam int CAP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_PREV   = 3'd2,
        CMD_NEXT   = 3'd3,
        CMD_COUNT  = 3'd4
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_INS_SHIFT,
        ENG_INS_VAL,
        ENG_REM_HEAD,
        ENG_REM_GRAB,
        ENG_REM_SHIFT,
        ENG_CNT_SCAN,
        ENG_DRAIN,
        ENG_DONE
    } eng_state_t;

    // One command beat.
    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } cmd_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [4:0]               match_count;
        logic [1:0]               status;
        logic [4:0]               list_length;
        logic [4:0]               cursor_position;
    } rsp_beat_t;

    // Engine status toward the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_ctl_t;

endpackage : cal_pkg
`default_nettype wire

// ----- rtl/core/cal_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ram
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : cal_ram
`default_nettype wire

// ----- rtl/core/cal_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cal_step
// Shared index unit: steps an index up or down by one and flags when the
// stepped index reaches a limit.
// ----------------------------------------------------------------------------
module cal_step (
    input  wire logic [cal_pkg::CNT_W-1:0] idx,
    input  wire logic                      down,
    input  wire logic [cal_pkg::CNT_W-1:0] limit,
    output logic      [cal_pkg::CNT_W-1:0] nxt,
    output logic                           hit
);
    import cal_pkg::*;

    // Increment or decrement, then compare with the limit.
    always_comb
    begin
        if (down)
        begin
            nxt = idx - CNT_W'(1);
        end
        else
        begin
            nxt = idx + CNT_W'(1);
        end
        hit = (nxt == limit);
    end

endmodule : cal_step
`default_nettype wire

// ----- rtl/core/cal_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cal_engine
// Command sequencer: walks the entry store one access per cycle for insert,
// remove and count, using the shared index unit, and keeps length and cursor.
// ----------------------------------------------------------------------------
module cal_engine (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire cal_pkg::cmd_beat_t        cmd,
    input  wire logic [cal_pkg::CAP_W-1:0] capacity,
    input  wire logic                      slot_free,
    output cal_pkg::eng_ctl_t              ctl,
    output cal_pkg::rsp_beat_t             result
);
    import cal_pkg::*;

    eng_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [CNT_W-1:0]         cursor_reg, cursor_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pend_addr_reg, pend_addr_next;
    logic [2:0]               cmd_reg, cmd_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    status_t                  status_reg, status_next;
    logic [DATA_W-1:0]        removed_reg, removed_next;
    logic [CNT_W-1:0]         match_reg, match_next;

    logic [CNT_W-1:0]         step_idx, step_limit, step_nxt;
    logic                     step_down, step_hit;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr, mem_raddr;
    logic [DATA_W-1:0]        mem_wdata, mem_rdata;

    logic                     is_full;
    logic                     cmd_is_count;

    cal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cal_step u_step (
        .idx   (step_idx),
        .down  (step_down),
        .limit (step_limit),
        .nxt   (step_nxt),
        .hit   (step_hit)
    );

    assign is_full      = (CAP_W'(used_reg) >= capacity);
    assign cmd_is_count = (cmd_code_t'(cmd_reg) == CMD_COUNT);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ENG_IDLE;
            used_reg   <= '0;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        removed_reg   <= removed_next;
        match_reg     <= match_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    case (cmd_code_t'(cmd.command))
                        CMD_INSERT:
                        begin
                            if (is_full)
                                state_next = ENG_DONE;
                            else if (cursor_reg == used_reg)
                                state_next = ENG_INS_VAL;
                            else
                                state_next = ENG_INS_SHIFT;
                        end
                        CMD_REMOVE:
                        begin
                            if (cursor_reg >= used_reg)
                                state_next = ENG_DONE;
                            else
                                state_next = ENG_REM_HEAD;
                        end
                        CMD_COUNT:
                        begin
                            if (used_reg == '0)
                                state_next = ENG_DONE;
                            else
                                state_next = ENG_CNT_SCAN;
                        end
                        default:
                        begin
                            state_next = ENG_DONE;
                        end
                    endcase
                end
            end
            ENG_REM_HEAD:
            begin
                state_next = ENG_REM_GRAB;
            end
            ENG_REM_GRAB:
            begin
                state_next = step_hit ? ENG_DONE : ENG_REM_SHIFT;
            end
            ENG_INS_SHIFT, ENG_REM_SHIFT, ENG_CNT_SCAN:
            begin
                if (step_hit)
                    state_next = ENG_DRAIN;
            end
            ENG_DRAIN:
            begin
                if (cmd_code_t'(cmd_reg) == CMD_INSERT)
                    state_next = ENG_INS_VAL;
                else
                    state_next = ENG_DONE;
            end
            ENG_INS_VAL:
            begin
                state_next = ENG_DONE;
            end
            ENG_DONE:
            begin
                if (slot_free)
                    state_next = ENG_IDLE;
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        used_next      = used_reg;
        cursor_next    = cursor_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        match_next     = match_reg;
        step_idx       = idx_reg;
        step_down      = 1'b0;
        step_limit     = used_reg;
        mem_raddr      = idx_reg[IDX_W-1:0];

        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd.command;
                    val_next     = cmd.value;
                    status_next  = ST_OK;
                    removed_next = '0;
                    match_next   = '0;
                    case (cmd_code_t'(cmd.command))
                        CMD_INSERT:
                        begin
                            if (is_full)
                                status_next = ST_FULL;
                            idx_next = used_reg;
                        end
                        CMD_REMOVE:
                        begin
                            if (cursor_reg >= used_reg)
                            begin
                                status_next  = ST_EMPTY;
                                removed_next = '1;
                            end
                        end
                        CMD_PREV:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - CNT_W'(1);
                        end
                        CMD_NEXT:
                        begin
                            if (cursor_reg < used_reg)
                                cursor_next = cursor_reg + CNT_W'(1);
                        end
                        CMD_COUNT:
                        begin
                            idx_next = '0;
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                end
            end
            ENG_REM_HEAD:
            begin
                mem_raddr = cursor_reg[IDX_W-1:0];
            end
            ENG_REM_GRAB:
            begin
                // The entry at the cursor leaves; shift only if entries follow it.
                removed_next = mem_rdata;
                step_idx     = cursor_reg;
                idx_next     = cursor_reg;
                if (step_hit)
                    used_next = used_reg - CNT_W'(1);
            end
            ENG_INS_SHIFT:
            begin
                // Read the entry below, write it one place up next cycle.
                step_down      = 1'b1;
                step_limit     = cursor_reg;
                mem_raddr      = step_nxt[IDX_W-1:0];
                pend_next      = 1'b1;
                pend_addr_next = idx_reg[IDX_W-1:0];
                idx_next       = step_nxt;
            end
            ENG_REM_SHIFT:
            begin
                // Read the entry above, write it one place down next cycle.
                step_limit     = used_reg - CNT_W'(1);
                mem_raddr      = step_nxt[IDX_W-1:0];
                pend_next      = 1'b1;
                pend_addr_next = idx_reg[IDX_W-1:0];
                idx_next       = step_nxt;
            end
            ENG_CNT_SCAN:
            begin
                pend_next = 1'b1;
                idx_next  = step_nxt;
            end
            ENG_DRAIN:
            begin
                if (cmd_code_t'(cmd_reg) == CMD_REMOVE)
                    used_next = used_reg - CNT_W'(1);
            end
            ENG_INS_VAL:
            begin
                used_next = used_reg + CNT_W'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        // Count compares the word read in the previous cycle.
        if (pend_reg && cmd_is_count && (mem_rdata == val_reg))
            match_next = match_reg + CNT_W'(1);
    end

    // Store write: a shifted word, or the inserted value at the cursor.
    always_comb
    begin
        if (state_reg == ENG_INS_VAL)
        begin
            mem_we    = 1'b1;
            mem_waddr = cursor_reg[IDX_W-1:0];
            mem_wdata = val_reg;
        end
        else
        begin
            mem_we    = pend_reg && !cmd_is_count;
            mem_waddr = pend_addr_reg;
            mem_wdata = mem_rdata;
        end
    end

    // Result and status.
    always_comb
    begin
        ctl.busy               = (state_reg != ENG_IDLE);
        ctl.done               = (state_reg == ENG_DONE) && slot_free;
        result.removed_value   = removed_reg;
        result.match_count     = 5'(match_reg);
        result.status          = status_reg;
        result.list_length     = 5'(used_reg);
        result.cursor_position = 5'(cursor_reg);
    end

    // The length never exceeds the built depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(DEPTH))
        else $error("list length exceeds depth");

    // The cursor always sits within the list.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= used_reg)
        else $error("cursor beyond list end");

    // No store write while waiting for a command.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_IDLE) |-> !mem_we)
        else $error("store written while idle");

    // Length and cursor hold while the count walk is in progress.
    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_CNT_SCAN) |=> $stable(used_reg) && $stable(cursor_reg))
        else $error("state changed during count walk");

endmodule : cal_engine
`default_nettype wire

// ----- rtl/core/cursor_array_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_array_list
// Ordered list of signed 32-bit values in a fixed store with a cursor.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat. The block handles one
// command at a time and holds cmd_stall high while it works. Prev, next, a
// dropped insert, a remove at the list end and unused codes finish without
// touching the store. Insert moves the entries from the cursor to the list
// end up one place and then writes the value at the cursor, remove moves the
// entries after the cursor down one place, and count reads every entry. The
// walk moves one stored word per cycle through the single-port-read entry
// RAM. A finished result sits in an output register, so the next command is
// accepted while the previous result waits on rsp_stall. The store needs no
// clearing pass.
// ----------------------------------------------------------------------------
module cursor_array_list (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           max_entries_we,
    input  wire logic [cal_pkg::MAXE_W-1:0]     max_entries_wdata,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire cal_pkg::cmd_beat_t             cmd,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output cal_pkg::rsp_beat_t                  rsp
);
    import cal_pkg::*;

    logic [MAXE_W-1:0] max_entries_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_beat_t         rsp_reg;
    logic [CAP_W-1:0]  capacity;
    logic              slot_free;
    logic              start;
    eng_ctl_t          eng_ctl;
    rsp_beat_t         eng_result;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_entries_reg <= MAXE_W'(16);
        else if (max_entries_we)
            max_entries_reg <= max_entries_wdata;
    end

    // Capacity in use is the smaller of the register and the built depth.
    always_comb
    begin
        if (CAP_W'(max_entries_reg) < CAP_W'(DEPTH))
            capacity = CAP_W'(max_entries_reg);
        else
            capacity = CAP_W'(DEPTH);
    end

    // Command handshake.
    assign cmd_stall = eng_ctl.busy;
    assign start     = cmd_valid && !eng_ctl.busy;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    cal_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .capacity  (capacity),
        .slot_free (slot_free),
        .ctl       (eng_ctl),
        .result    (eng_result)
    );

    // Output register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (eng_ctl.done)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (eng_ctl.done)
            rsp_reg <= eng_result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : cursor_array_list
`default_nettype wire
